/* src/jtag_shift_sequencer_core_defines.svh */
// ----------------------------------------------------------------------------
// JTAG shift sequencer assertion macros
// Shared property shorthands, clocked on i_clk and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef JTAG_SHIFT_SEQUENCER_CORE_DEFINES_SVH
`define JTAG_SHIFT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication
`define JSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define JSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/jss_pkg.sv */
// ----------------------------------------------------------------------------
// JTAG shift sequencer package
// Microcode word layout, program ROM contents and shared constants.
// ----------------------------------------------------------------------------
package jss_pkg;

    localparam int IR_BITS_DEF     = 16;
    localparam int BYPASS_BITS_DEF = 10;
    localparam int BYTE_BITS       = 8;
    localparam int ADDR_W          = 5;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_IR    = 2'd2,
        MODE_DATA  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TMS_KEEP,
        TMS_LO,
        TMS_HI
    } t_tms_op;

    // TDI update applied after the pulse
    typedef enum logic [1:0] {
        TDI_KEEP,
        TDI_SHIFT,
        TDI_ONE,
        TDI_ZERO
    } t_tdi_op;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_IR,
        CNT_BYP,
        CNT_BYTE
    } t_cnt_sel;

    typedef enum logic [1:0] {
        ACT_NEXT,
        ACT_JUMP,
        ACT_DONE
    } t_act;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_PAUSE,
        C_NPAUSE,
        C_NFIRST,
        C_NLAST
    } t_cond;

    typedef struct packed {
        t_tms_op             tms;
        t_tdi_op             tdi;
        t_cnt_sel            cnt_ld;
        logic                loop;
        logic                emit;
        t_act                act;
        t_cond               cond;
        logic [ADDR_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        logic   load;
        logic   step;
        logic   run;
        logic   emit;
        t_uword word;
    } t_ctrl;

    typedef struct packed {
        logic busy;
        logic finish;
        logic is_data;
    } t_seq_stat;

    // Program entry points and jump targets
    localparam logic [ADDR_W-1:0] A_RESET    = 5'd0;
    localparam logic [ADDR_W-1:0] A_IDLE     = 5'd6;
    localparam logic [ADDR_W-1:0] A_IR       = 5'd7;
    localparam logic [ADDR_W-1:0] A_IR_END   = 5'd16;
    localparam logic [ADDR_W-1:0] A_DATA     = 5'd17;
    localparam logic [ADDR_W-1:0] A_PRE_IDLE = 5'd22;
    localparam logic [ADDR_W-1:0] A_PRE_TAIL = 5'd24;
    localparam logic [ADDR_W-1:0] A_BYTE     = 5'd26;
    localparam logic [ADDR_W-1:0] A_NONE     = 5'd0;

    function automatic t_uword mk_word(t_tms_op tms, t_tdi_op tdi, t_cnt_sel cnt_ld,
                                       logic loop, logic emit, t_act act, t_cond cond,
                                       logic [ADDR_W-1:0] target);
        t_uword w;
        w.tms    = tms;
        w.tdi    = tdi;
        w.cnt_ld = cnt_ld;
        w.loop   = loop;
        w.emit   = emit;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] mode_entry(t_mode mode);
        logic [ADDR_W-1:0] a;
        case (mode)
            MODE_RESET: a = A_RESET;
            MODE_IDLE:  a = A_IDLE;
            MODE_IR:    a = A_IR;
            MODE_DATA:  a = A_DATA;
            default:    a = A_RESET;
        endcase
        return a;
    endfunction

    function automatic t_uword ucode(logic [ADDR_W-1:0] addr);
        t_uword w;
        case (addr)
            // TAP reset: six TCK pulses with TMS high
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4:
                w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd5:  w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_DONE, C_ALWAYS, A_NONE);
            // go idle
            5'd6:  w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_DONE, C_ALWAYS, A_NONE);
            // IR scan: idle, select DR, select IR, capture, shift
            5'd7:  w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd8:  w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd9:  w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd10: w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd11: w = mk_word(TMS_LO, TDI_KEEP, CNT_IR,   1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd12: w = mk_word(TMS_KEEP, TDI_SHIFT, CNT_BYP, 1'b1, 1'b0, ACT_NEXT, C_ALWAYS,
                               A_NONE);
            5'd13: w = mk_word(TMS_KEEP, TDI_ONE, CNT_NONE, 1'b1, 1'b0, ACT_NEXT, C_ALWAYS,
                               A_NONE);
            5'd14: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_JUMP, C_PAUSE,
                               A_IR_END);
            5'd15: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd16: w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_DONE, C_ALWAYS, A_NONE);
            // data byte: optional preamble
            5'd17: w = mk_word(TMS_KEEP, TDI_KEEP, CNT_BYTE, 1'b0, 1'b0, ACT_JUMP, C_NFIRST,
                               A_BYTE);
            5'd18: w = mk_word(TMS_KEEP, TDI_KEEP, CNT_NONE, 1'b0, 1'b0, ACT_JUMP, C_NPAUSE,
                               A_PRE_IDLE);
            5'd19: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd20: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd21: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_JUMP, C_ALWAYS,
                               A_PRE_TAIL);
            5'd22: w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd23: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd24: w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd25: w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            // byte body: seven looped bits, then the last bit
            5'd26: w = mk_word(TMS_KEEP, TDI_SHIFT, CNT_NONE, 1'b1, 1'b0, ACT_NEXT, C_ALWAYS,
                               A_NONE);
            5'd27: w = mk_word(TMS_KEEP, TDI_SHIFT, CNT_NONE, 1'b0, 1'b1, ACT_DONE, C_NLAST,
                               A_NONE);
            // closing tail
            5'd28: w = mk_word(TMS_KEEP, TDI_ZERO, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS,
                               A_NONE);
            5'd29: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd30: w = mk_word(TMS_HI, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_NEXT, C_ALWAYS, A_NONE);
            5'd31: w = mk_word(TMS_LO, TDI_KEEP, CNT_NONE, 1'b0, 1'b1, ACT_DONE, C_ALWAYS, A_NONE);
            default:
                w = mk_word(TMS_KEEP, TDI_KEEP, CNT_NONE, 1'b0, 1'b0, ACT_DONE, C_ALWAYS, A_NONE);
        endcase
        return w;
    endfunction

endpackage

/* src/jss_cmd_if.sv */
// ----------------------------------------------------------------------------
// JTAG shift sequencer command channel
// Valid/ready channel carrying one command per transaction.
// ----------------------------------------------------------------------------
interface jss_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] ir_value;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        end_in_pause;
    logic [7:0]  tdo_bits;

    modport source (
        output valid, mode, ir_value, data_byte, first_byte, last_byte, end_in_pause,
               tdo_bits,
        input  ready
    );

    modport sink (
        input  valid, mode, ir_value, data_byte, first_byte, last_byte, end_in_pause,
               tdo_bits,
        output ready
    );
endinterface

/* src/jss_pulse_if.sv */
// ----------------------------------------------------------------------------
// JTAG shift sequencer pulse channel
// Valid/ready channel carrying one TCK pulse description per transaction.
// ----------------------------------------------------------------------------
interface jss_pulse_if;
    logic       valid;
    logic       ready;
    logic       tms_level;
    logic       tdi_level;
    logic [7:0] captured_byte;
    logic       last_pulse;

    modport source (
        output valid, tms_level, tdi_level, captured_byte, last_pulse,
        input  ready
    );

    modport sink (
        input  valid, tms_level, tdi_level, captured_byte, last_pulse,
        output ready
    );
endinterface

/* src/jtag_shift_sequencer_core.sv */
// First pulse: the command transaction loads the program counter, then the first emitting step
// fills the output register; a data byte first steps through its non-emitting preamble words.
// Rate is set by the single microcode step per cycle, held while the output register is stalled;
// each repeat loop ends with an exit step that emits no pulse.
// Reset (synchronous, active low) clears TMS/TDI hold levels, sequencer and output valid.
// ----------------------------------------------------------------------------
// JTAG shift sequencer core
// Microcoded TAP master: one command in, one pulse transaction per TCK clock out.
// ----------------------------------------------------------------------------
`include "jtag_shift_sequencer_core_defines.svh"

module jtag_shift_sequencer_core import jss_pkg::*; #(
    parameter int IR_BITS     = IR_BITS_DEF,
    parameter int BYPASS_BITS = BYPASS_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jss_cmd_if.sink      i_cmd,
    jss_pulse_if.source  o_pulse
);

    // Sequencer <-> ROM <-> datapath
    logic [ADDR_W-1:0] pc;
    t_uword            word;
    t_ctrl             ctrl;
    t_seq_stat         stat;
    logic              cnt_zero;
    logic              dp_tms, dp_tdi;
    logic [7:0]        dp_tdo;

    // Output register: holds one pulse while the sink is stalled
    logic              r_out_valid, n_out_valid;
    logic              r_out_tms, r_out_tdi, r_out_last;
    logic [7:0]        r_out_cap;

    logic              cmd_acc;
    logic              stall;

    // One command at a time; a new one is taken the cycle after the final step.
    assign i_cmd.ready = !stat.busy;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // Hold the program while a finished pulse is still waiting.
    assign stall = r_out_valid && !o_pulse.ready;

    jss_ucode_rom u_rom (
        .i_addr (pc),
        .o_word (word)
    );

    jss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (cmd_acc),
        .i_mode     (i_cmd.mode),
        .i_first    (i_cmd.first_byte),
        .i_last     (i_cmd.last_byte),
        .i_pause    (i_cmd.end_in_pause),
        .i_stall    (stall),
        .i_cnt_zero (cnt_zero),
        .i_word     (word),
        .o_pc       (pc),
        .o_ctrl     (ctrl),
        .o_stat     (stat)
    );

    jss_dp #(
        .IR_BITS     (IR_BITS),
        .BYPASS_BITS (BYPASS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_mode      (i_cmd.mode),
        .i_ir_value  (i_cmd.ir_value),
        .i_data_byte (i_cmd.data_byte),
        .i_tdo_bits  (i_cmd.tdo_bits),
        .o_tms       (dp_tms),
        .o_tdi       (dp_tdi),
        .o_tdo       (dp_tdo),
        .o_cnt_zero  (cnt_zero)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.step && ctrl.emit) begin
            n_out_valid = 1'b1;
        end else if (o_pulse.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Pulse payload: TDI is the level held before this clock's update.
    // Captured byte only rides the final pulse of a data byte.
    always_ff @(posedge i_clk) begin
        if (ctrl.step && ctrl.emit) begin
            r_out_tms  <= dp_tms;
            r_out_tdi  <= dp_tdi;
            r_out_last <= stat.finish;
            r_out_cap  <= (stat.finish && stat.is_data) ? dp_tdo : 8'd0;
        end
    end

    assign o_pulse.valid         = r_out_valid;
    assign o_pulse.tms_level     = r_out_tms;
    assign o_pulse.tdi_level     = r_out_tdi;
    assign o_pulse.captured_byte = r_out_cap;
    assign o_pulse.last_pulse    = r_out_last;

    // Checks
    `JSS_ASSERT_IMP(a_cap_on_last, o_pulse.valid && !o_pulse.last_pulse,
                    o_pulse.captured_byte == 8'd0, "captured byte outside final pulse")
    `JSS_ASSERT_IMP(a_no_acc_busy, cmd_acc, !stat.busy, "command taken while busy")
    `JSS_ASSERT_NXT(a_busy_after_acc, cmd_acc, stat.busy, "sequencer idle after command")
    `JSS_ASSERT_NXT(a_finish_frees, stat.finish,
                    !stat.busy && o_pulse.valid && o_pulse.last_pulse,
                    "final step did not release sequencer")

endmodule

/* src/jss_ucode_rom.sv */
// ----------------------------------------------------------------------------
// JTAG shift sequencer microcode ROM
// Constant program store, one control word per address.
// ----------------------------------------------------------------------------
module jss_ucode_rom import jss_pkg::*; (
    input  logic [ADDR_W-1:0] i_addr,
    output t_uword            o_word
);

    assign o_word = ucode(i_addr);

endmodule

/* src/jss_seq.sv */
// ----------------------------------------------------------------------------
// JTAG shift sequencer program counter
// Step counter, dispatch on command mode and conditional jumps.
// ----------------------------------------------------------------------------
module jss_seq import jss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_mode,
    input  logic              i_first,
    input  logic              i_last,
    input  logic              i_pause,
    input  logic              i_stall,
    input  logic              i_cnt_zero,
    input  t_uword            i_word,
    output logic [ADDR_W-1:0] o_pc,
    output t_ctrl             o_ctrl,
    output t_seq_stat         o_stat
);

    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_busy, n_busy;
    logic              r_first, r_last, r_pause, r_data;
    logic              step, run, emit, cond_ok, finish;

    assign step = r_busy && !i_stall;
    assign run  = i_word.loop && !i_cnt_zero;
    assign emit = i_word.loop ? !i_cnt_zero : i_word.emit;

    always_comb begin
        case (i_word.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_PAUSE:  cond_ok = r_pause;
            C_NPAUSE: cond_ok = !r_pause;
            C_NFIRST: cond_ok = !r_first;
            C_NLAST:  cond_ok = !r_last;
            default:  cond_ok = 1'b1;
        endcase
    end

    assign finish = step && !run && (i_word.act == ACT_DONE) && cond_ok;

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_accept) begin
            n_pc   = mode_entry(t_mode'(i_mode));
            n_busy = 1'b1;
        end else if (finish) begin
            n_busy = 1'b0;
        end else if (step && !run) begin
            if ((i_word.act == ACT_JUMP) && cond_ok) begin
                n_pc = i_word.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    // command flags, held for the life of the command
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_first <= i_first;
            r_last  <= i_last;
            r_pause <= i_pause;
            r_data  <= (t_mode'(i_mode) == MODE_DATA);
        end
    end

    assign o_pc           = r_pc;
    assign o_ctrl.load    = i_accept;
    assign o_ctrl.step    = step;
    assign o_ctrl.run     = run;
    assign o_ctrl.emit    = emit;
    assign o_ctrl.word    = i_word;
    assign o_stat.busy    = r_busy;
    assign o_stat.finish  = finish;
    assign o_stat.is_data = r_data;

endmodule

/* src/jss_dp.sv */
// ----------------------------------------------------------------------------
// JTAG shift sequencer datapath
// TMS/TDI hold registers, shift register and repeat counter.
// ----------------------------------------------------------------------------
module jss_dp import jss_pkg::*; #(
    parameter int IR_BITS     = IR_BITS_DEF,
    parameter int BYPASS_BITS = BYPASS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_ir_value,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_tdo_bits,
    output logic        o_tms,
    output logic        o_tdi,
    output logic [7:0]  o_tdo,
    output logic        o_cnt_zero
);

    localparam int SR_W    = (IR_BITS > BYTE_BITS) ? IR_BITS : BYTE_BITS;
    localparam int EXT_W   = (SR_W > 16) ? SR_W : 16;
    localparam int CNT_MAX = (IR_BITS > BYPASS_BITS) ? IR_BITS : BYPASS_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [SR_W-1:0]  r_sr, n_sr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_tms, n_tms, r_tdi, n_tdi;
    logic [7:0]       r_tdo;
    logic [EXT_W-1:0] ir_ext;
    logic             tms_now;

    assign ir_ext = EXT_W'(i_ir_value);

    always_comb begin
        case (i_ctrl.word.tms)
            TMS_LO:  tms_now = 1'b0;
            TMS_HI:  tms_now = 1'b1;
            default: tms_now = r_tms;
        endcase
    end

    always_comb begin
        n_tms = r_tms;
        n_tdi = r_tdi;
        n_sr  = r_sr;
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            if (t_mode'(i_mode) == MODE_DATA) begin
                n_sr = SR_W'(i_data_byte);
            end else begin
                n_sr = ir_ext[SR_W-1:0];
            end
        end else if (i_ctrl.step) begin
            n_tms = tms_now;
            if (i_ctrl.emit) begin
                case (i_ctrl.word.tdi)
                    TDI_SHIFT: begin
                        n_tdi = r_sr[0];
                        n_sr  = r_sr >> 1;
                    end
                    TDI_ONE:   n_tdi = 1'b1;
                    TDI_ZERO:  n_tdi = 1'b0;
                    default:   n_tdi = r_tdi;
                endcase
            end
            if (i_ctrl.run) begin
                n_cnt = r_cnt - 1'b1;
            end else begin
                case (i_ctrl.word.cnt_ld)
                    CNT_IR:   n_cnt = CNT_W'(IR_BITS);
                    CNT_BYP:  n_cnt = CNT_W'(BYPASS_BITS);
                    CNT_BYTE: n_cnt = CNT_W'(BYTE_BITS - 1);
                    default:  n_cnt = r_cnt;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tms <= 1'b0;
            r_tdi <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_tms <= n_tms;
            r_tdi <= n_tdi;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= n_sr;
        if (i_ctrl.load) begin
            r_tdo <= i_tdo_bits;
        end
    end

    assign o_tms      = tms_now;
    assign o_tdi      = r_tdi;
    assign o_tdo      = r_tdo;
    assign o_cnt_zero = (r_cnt == '0);

endmodule

/* verif/jss_pulse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG shift sequencer pulse checker
// Watches both channels, works out the TCK pulse train that each accepted
// command must give and compares every pulse transaction field by field.
// ----------------------------------------------------------------------------
module jss_pulse_checker import jss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jss_cmd_if    i_cmd,
    jss_pulse_if  i_pulse,
    output int    o_fail_count,
    output int    o_pending_count
);

    typedef struct packed {
        logic       tms;
        logic       tdi;
        logic [7:0] captured;
        logic       last;
    } t_tck_pulse;

    t_tck_pulse pulse_q[$];
    t_tck_pulse staged;
    bit         have_staged;
    logic       tms_drive;
    logic       tdi_drive;
    int         mismatches;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        mismatches      = 0;
        have_staged     = 1'b0;
        tms_drive       = 1'b0;
        tdi_drive       = 1'b0;
    end

    // The newest pulse is held back so the final one can be marked.
    function automatic void stage_pulse();
        if (have_staged) begin
            pulse_q.push_back(staged);
        end
        staged      = {tms_drive, tdi_drive, 8'h00, 1'b0};
        have_staged = 1'b1;
    endfunction

    function automatic void hold_tms(input logic level, input int count);
        tms_drive = level;
        repeat (count) stage_pulse();
    endfunction

    // TDI moves only after the clock, hence the one-bit lag
    function automatic void shift_tdi(input logic next_bit);
        stage_pulse();
        tdi_drive = next_bit;
    endfunction

    task automatic plan_command_pulses(input t_mode mode, input logic [15:0] ir,
                                       input logic [7:0] data, input logic first,
                                       input logic last, input logic pause,
                                       input logic [7:0] tdo);
        int i;
        case (mode)
            MODE_RESET: hold_tms(1'b1, 6);
            MODE_IDLE:  hold_tms(1'b0, 1);
            MODE_IR: begin
                hold_tms(1'b0, 1);
                hold_tms(1'b1, 2);
                hold_tms(1'b0, 2);
                for (i = 0; i < IR_BITS_DEF; i++) begin
                    shift_tdi((i < 16) ? ir[i] : 1'b0);
                end
                for (i = 0; i < BYPASS_BITS_DEF; i++) begin
                    shift_tdi(1'b1);
                end
                if (pause) begin
                    hold_tms(1'b1, 1);
                    hold_tms(1'b0, 1);
                end else begin
                    hold_tms(1'b1, 2);
                    hold_tms(1'b0, 1);
                end
            end
            default: begin
                if (first) begin
                    if (pause) begin
                        hold_tms(1'b1, 3);
                        hold_tms(1'b0, 2);
                    end else begin
                        hold_tms(1'b0, 1);
                        hold_tms(1'b1, 1);
                        hold_tms(1'b0, 2);
                    end
                end
                for (i = 0; i < BYTE_BITS; i++) begin
                    shift_tdi(data[i]);
                end
                if (last) begin
                    shift_tdi(1'b0);
                    hold_tms(1'b1, 2);
                    hold_tms(1'b0, 1);
                end
                staged.captured = tdo;
            end
        endcase
        staged.last = 1'b1;
        pulse_q.push_back(staged);
        have_staged = 1'b0;
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tck_pulse want;
        if (!i_rst_n) begin
            tms_drive   = 1'b0;
            tdi_drive   = 1'b0;
            have_staged = 1'b0;
        end else begin
            // Pulses first: none can stem from a command taken at this same edge
            if (i_pulse.valid && i_pulse.ready) begin
                if (pulse_q.size() == 0) begin
                    $error("pulse transaction arrived with no pulse pending");
                    mismatches++;
                end else begin
                    want = pulse_q.pop_front();
                    check_field("tms_level", {7'd0, want.tms}, {7'd0, i_pulse.tms_level});
                    check_field("tdi_level", {7'd0, want.tdi}, {7'd0, i_pulse.tdi_level});
                    check_field("captured_byte", want.captured, i_pulse.captured_byte);
                    check_field("last_pulse", {7'd0, want.last}, {7'd0, i_pulse.last_pulse});
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                plan_command_pulses(t_mode'(i_cmd.mode), i_cmd.ir_value, i_cmd.data_byte,
                                    i_cmd.first_byte, i_cmd.last_byte, i_cmd.end_in_pause,
                                    i_cmd.tdo_bits);
            end
        end
        o_fail_count    <= mismatches;
        o_pending_count <= pulse_q.size();
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG shift sequencer testbench
// Drives TAP reset, idle, instruction and data byte commands with random
// gaps and back-pressure; the pulse checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import jss_pkg::*;

    localparam int RANDOM_ITEMS     = 230;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int MAX_WAIT         = 13;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] ir;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        pause;
        logic [7:0]  tdo;
    } t_cmd_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;

    // Process state; no_idle and long_hold_req are shared between the command and pulse processes
    bit   no_idle;
    bit   long_hold_req;
    bit   cmd_offered;
    int   next_gap;
    int   sent_items;

    jss_cmd_if   cmd_ch();
    jss_pulse_if pulse_ch();

    jtag_shift_sequencer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_pulse (pulse_ch)
    );

    jss_pulse_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_pulse         (pulse_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle cycles before a transaction; none at all while a burst stretch runs
    function automatic int draw_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_cmd_item make_cmd(input t_mode mode, input logic [15:0] ir,
                                           input logic [7:0] data, input logic first,
                                           input logic last, input logic pause,
                                           input logic [7:0] tdo);
        t_cmd_item item;
        item.mode  = mode;
        item.ir    = ir;
        item.data  = data;
        item.first = first;
        item.last  = last;
        item.pause = pause;
        item.tdo   = tdo;
        return item;
    endfunction

    // Drops valid once only, so it is never lowered and raised in one step
    task automatic idle_sender();
        if (cmd_offered) begin
            cmd_ch.valid <= 1'b0;
            cmd_offered = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    // The gap ahead of the next command is drawn here, so valid stays high
    // straight through back-to-back transactions.
    task automatic send_cmd(input t_cmd_item item);
        repeat (next_gap) @(negedge i_clk);
        cmd_offered             = 1'b1;
        cmd_ch.valid           <= 1'b1;
        cmd_ch.mode            <= item.mode;
        cmd_ch.ir_value        <= item.ir;
        cmd_ch.data_byte       <= item.data;
        cmd_ch.first_byte      <= item.first;
        cmd_ch.last_byte       <= item.last;
        cmd_ch.end_in_pause    <= item.pause;
        cmd_ch.tdo_bits        <= item.tdo;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
        next_gap = draw_wait();
        if (next_gap != 0) begin
            idle_sender();
        end
    endtask

    // Pulse receiver: random stall per transaction, plus one long hold-off
    // on request so the core fills up and refuses further commands.
    initial begin
        int stall;
        int held;
        pulse_ch.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                pulse_ch.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD_CYCLES; held++) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                stall = draw_wait();
                if (stall != 0) begin
                    pulse_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                pulse_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (!pulse_ch.valid) @(posedge i_clk);
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int          base;
        int          nbytes;
        int          b;
        logic [31:0] w;
        logic [31:0] w2;
        bit          hold_done;
        bit          drain_done;

        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.mode         = MODE_RESET;
        cmd_ch.ir_value     = 16'h0000;
        cmd_ch.data_byte    = 8'h00;
        cmd_ch.first_byte   = 1'b0;
        cmd_ch.last_byte    = 1'b0;
        cmd_ch.end_in_pause = 1'b0;
        cmd_ch.tdo_bits     = 8'h00;
        no_idle             = 1'b0;
        long_hold_req       = 1'b0;
        cmd_offered         = 1'b0;
        next_gap            = 0;
        sent_items          = 0;
        hold_done           = 1'b0;
        drain_done          = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every mode, both endings, field extremes, and byte marks
        // given out of order (closing mark with no opener, opener twice).
        send_cmd(make_cmd(MODE_RESET, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_cmd(make_cmd(MODE_IDLE,  16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_cmd(make_cmd(MODE_IR,    16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
        send_cmd(make_cmd(MODE_IR,    16'h0000, 8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF));
        send_cmd(make_cmd(MODE_IR,    16'hA5C3, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00));
        send_cmd(make_cmd(MODE_DATA,  16'hFFFF, 8'h00, 1'b1, 1'b0, 1'b0, 8'hFF));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'h5A, 1'b0, 1'b0, 1'b0, 8'hA5));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'hA5, 1'b0, 1'b1, 1'b0, 8'h5A));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'h01, 1'b1, 1'b0, 1'b1, 8'h80));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'h80, 1'b1, 1'b1, 1'b0, 8'h01));
        send_cmd(make_cmd(MODE_RESET, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
        send_cmd(make_cmd(MODE_IR,    16'h8001, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_cmd(make_cmd(MODE_IDLE,  16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
        send_cmd(make_cmd(MODE_DATA,  16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));

        // Random: mostly well-formed scans (optional reset and idle, an
        // instruction, then a run of bytes with opening and closing marks),
        // the rest fully random commands.
        base = sent_items;
        while (sent_items < base + RANDOM_ITEMS) begin
            if (!hold_done && sent_items >= base + 70) begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!drain_done && sent_items >= base + 150) begin
                // Sender waits here until the pulse train has fully drained
                drain_done = 1'b1;
                idle_sender();
                while (pending_count != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            if ($urandom_range(0, 5) == 0) begin
                no_idle = !no_idle;
            end
            w  = $urandom;
            w2 = $urandom;
            if ($urandom_range(0, 9) < 7) begin
                if (w2[0] && w2[1]) begin
                    send_cmd(make_cmd(MODE_RESET, w[15:0], w[23:16], w2[2], w2[3], w2[4],
                                      w[31:24]));
                end
                if (w2[5]) begin
                    send_cmd(make_cmd(MODE_IDLE, w[15:0], w[23:16], w2[2], w2[3], w2[4],
                                      w[31:24]));
                end
                send_cmd(make_cmd(MODE_IR, w[15:0], w[23:16], w2[6], w2[7], w2[8], w[31:24]));
                nbytes = w2[9] ? $urandom_range(1, 8) : $urandom_range(1, 3);
                for (b = 0; b < nbytes; b++) begin
                    w  = $urandom;
                    w2 = $urandom;
                    send_cmd(make_cmd(MODE_DATA, w[15:0], w[23:16], b == 0, b == nbytes - 1,
                                      w2[0], w2[15:8]));
                end
            end else begin
                send_cmd(make_cmd(t_mode'(w[1:0]), w[17:2], w[25:18], w2[0], w2[1], w2[2],
                                  w2[15:8]));
            end
        end

        idle_sender();
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("[jtag_shift_sequencer_core] OK");
        end else begin
            $display("[jtag_shift_sequencer_core] ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #8000000;
        $display("[jtag_shift_sequencer_core] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/jss_pkg.sv
src/jss_cmd_if.sv
src/jss_pulse_if.sv
src/jss_ucode_rom.sv
src/jss_seq.sv
src/jss_dp.sv
src/jtag_shift_sequencer_core.sv
verif/jss_pulse_checker.sv
verif/testbench.sv
